// ===== rtl/core/com_pkg.sv =====
// com_pkg: shared types and constants of the cell outflow minimization unit
// no dependencies
`default_nettype none
package com_pkg;
  localparam int unsigned WORD_W = 32;
  localparam int unsigned FLOW_W = 31;
  localparam int unsigned RATE_W = 17;
  localparam int unsigned NBR_N  = 4;
  localparam int unsigned CELL_N = NBR_N + 1;
  // wide sum: up to 5 cells of 33 bits plus mass
  localparam int unsigned SUM_W  = 37;
  localparam int unsigned PROD_W = SUM_W + 3;

  localparam logic [0:0] REG_EPSILON = 1'b0;
  localparam logic [0:0] REG_RATE    = 1'b1;

  localparam logic [FLOW_W-1:0] EPS_RESET  = 31'd66;
  localparam logic [RATE_W-1:0] RATE_RESET = 17'd32768;

  typedef logic signed [SUM_W-1:0]  sum_t;
  typedef logic [2:0]               cnt_t;

  typedef struct packed {
    logic [FLOW_W-1:0] center_debris;
    logic signed [WORD_W-1:0] center_altitude;
    logic signed [WORD_W-1:0] north_level;
    logic signed [WORD_W-1:0] west_level;
    logic signed [WORD_W-1:0] east_level;
    logic signed [WORD_W-1:0] south_level;
    logic [NBR_N-1:0] neighbour_present;
  } in_beat_t;

  typedef struct packed {
    logic [FLOW_W-1:0] flow_north;
    logic [FLOW_W-1:0] flow_west;
    logic [FLOW_W-1:0] flow_east;
    logic [FLOW_W-1:0] flow_south;
  } out_beat_t;

  // reciprocal of counts 1..5 in Q1.36 rounded up, exact for dividends below 2^34
  function automatic logic [36:0] recip(input cnt_t c);
    logic [36:0] r;
    begin
      case (c)
        3'd1:    r = 37'd68719476736;
        3'd2:    r = 37'd34359738368;
        3'd3:    r = 37'd22906492246;
        3'd4:    r = 37'd17179869184;
        3'd5:    r = 37'd13743895348;
        default: r = 37'd0;
      endcase
      return r;
    end
  endfunction
endpackage
`default_nettype wire

// ===== rtl/core/com_if.sv =====
// com_stream_if: valid/ready channel carrying one payload beat
// depends on nothing; payload type is a parameter
`default_nettype none
interface com_stream_if #(parameter type T = logic) (input wire logic clk);
  logic valid;
  logic ready;
  T     data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/com_elim.sv =====
// com_elim: one elimination pass over the five cells (registered stage)
// depends on com_pkg
`default_nettype none
module com_elim (
  input  wire logic                       clk,
  input  wire logic                       en,
  input  wire logic signed [com_pkg::SUM_W-1:0] mass,
  input  wire logic [com_pkg::CELL_N-1:0] gone_i,
  input  wire logic signed [com_pkg::SUM_W-1:0] u0,
  input  wire logic signed [com_pkg::SUM_W-1:0] u1,
  input  wire logic signed [com_pkg::SUM_W-1:0] u2,
  input  wire logic signed [com_pkg::SUM_W-1:0] u3,
  input  wire logic signed [com_pkg::SUM_W-1:0] u4,
  output logic [com_pkg::CELL_N-1:0]      gone_r,
  output logic signed [com_pkg::SUM_W-1:0] sum_r,
  output com_pkg::cnt_t                   cnt_r
);
  localparam int unsigned PROD_W = com_pkg::PROD_W;

  logic signed [com_pkg::SUM_W-1:0] u [com_pkg::CELL_N];
  logic signed [com_pkg::SUM_W-1:0] sum_nxt;
  com_pkg::cnt_t cnt_nxt;
  logic [com_pkg::CELL_N-1:0] gone_nxt;
  logic signed [PROD_W-1:0] lhs;

  assign u[0] = u0;
  assign u[1] = u1;
  assign u[2] = u2;
  assign u[3] = u3;
  assign u[4] = u4;

  // average and drop cells at or above it; sum/count describe the pass input set
  always_comb begin
    sum_nxt = mass;
    cnt_nxt = '0;
    for (int i = 0; i < com_pkg::CELL_N; i++) begin
      if (!gone_i[i]) begin
        sum_nxt = sum_nxt + u[i];
        cnt_nxt = cnt_nxt + 3'd1;
      end
    end
    for (int i = 0; i < com_pkg::CELL_N; i++) begin
      lhs = PROD_W'(u[i]) * $signed({1'b0, cnt_nxt});
      gone_nxt[i] = gone_i[i] || (lhs >= PROD_W'(sum_nxt));
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      gone_r <= gone_nxt;
      sum_r  <= sum_nxt;
      cnt_r  <= cnt_nxt;
    end
  end
endmodule
`default_nettype wire

// ===== rtl/core/cell_outflow_minimization_unit.sv =====
// cell_outflow_minimization_unit: top level, config regs and pipeline
// depends on com_pkg, com_stream_if, com_elim
//
// Usage: one stencil beat on in_ (centre debris and altitude, four neighbour
// levels, presence mask) gives one beat on out_ with four Q16.16 outflows.
// The elimination loop ends after at most five passes; each pass is one
// pipeline stage (com_elim), so the pipe has a setup stage, five pass stages,
// a difference stage, a rate multiply stage, a saturation and split
// reciprocal multiply stage and an output register. It takes one beat per
// cycle unless out_ready stalls it. The rate is set by the pass chain, one
// compare set per stage. The whole pipe advances together: when the receiver
// holds out_ready low with a beat waiting, every stage holds and in_ready
// goes low, so nothing is lost or repeated. A sync reset (rst_n low) clears
// all valid bits and loads epsilon 66 and rate 32768. The user must write
// registers over cfg_ only while idle; the unit itself does not enforce it.
`default_nettype none
module cell_outflow_minimization_unit #(
  parameter int unsigned PASSES = 5
) (
  input  wire logic clk,
  input  wire logic rst_n,
  com_stream_if.sink   in_,
  com_stream_if.source out_,
  input  wire logic        cfg_psel,
  input  wire logic        cfg_penable,
  input  wire logic        cfg_pwrite,
  input  wire logic [2:2]  cfg_paddr,
  input  wire logic [31:0] cfg_pwdata,
  output logic [31:0]      cfg_prdata,
  output logic             cfg_pready
);
  localparam int unsigned SW = com_pkg::SUM_W;
  localparam int unsigned NS = PASSES + 5;

  logic [com_pkg::FLOW_W-1:0] eps_r;
  logic [com_pkg::RATE_W-1:0] rate_r;
  logic adv;
  logic [NS-1:0] vld_r;

  // config registers
  assign cfg_pready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      eps_r  <= com_pkg::EPS_RESET;
      rate_r <= com_pkg::RATE_RESET;
    end else if (cfg_psel && cfg_penable && cfg_pwrite) begin
      unique case (cfg_paddr[2])
        com_pkg::REG_EPSILON: eps_r  <= cfg_pwdata[com_pkg::FLOW_W-1:0];
        com_pkg::REG_RATE:    rate_r <= cfg_pwdata[com_pkg::RATE_W-1:0];
        default: ;
      endcase
    end
  end
  always_comb begin
    unique case (cfg_paddr[2])
      com_pkg::REG_EPSILON: cfg_prdata = {1'b0, eps_r};
      com_pkg::REG_RATE:    cfg_prdata = {15'd0, rate_r};
      default:              cfg_prdata = '0;
    endcase
  end

  // global advance: stall only when the output beat is stuck
  assign adv       = !(vld_r[NS-1] && !out_.ready);
  assign in_.ready = adv;

  always_ff @(posedge clk) begin
    if (!rst_n) vld_r <= '0;
    else if (adv) vld_r <= {vld_r[NS-2:0], in_.valid};
  end

  // stage 0: operands
  logic signed [SW-1:0] u_r [com_pkg::CELL_N];
  logic signed [SW-1:0] m_r;
  logic [com_pkg::CELL_N-1:0] g0_r;
  always_ff @(posedge clk) begin
    if (adv) begin
      u_r[0] <= SW'(in_.data.center_altitude) + SW'({1'b0, eps_r});
      u_r[1] <= SW'(in_.data.north_level);
      u_r[2] <= SW'(in_.data.west_level);
      u_r[3] <= SW'(in_.data.east_level);
      u_r[4] <= SW'(in_.data.south_level);
      m_r    <= SW'({1'b0, in_.data.center_debris}) - SW'({1'b0, eps_r});
      // debris at or below epsilon: every cell out from the start
      g0_r   <= (in_.data.center_debris <= eps_r) ? '1 : {~in_.data.neighbour_present, 1'b0};
    end
  end

  // pass stages, operands travel alongside
  logic signed [SW-1:0] pu_r [PASSES+1][com_pkg::CELL_N];
  logic signed [SW-1:0] pm_r [PASSES+1];
  logic [com_pkg::CELL_N-1:0] pg [PASSES+1];
  logic signed [SW-1:0] ps [PASSES+1];
  com_pkg::cnt_t pc [PASSES+1];
  logic [com_pkg::CELL_N-1:0] pprev [PASSES+1];
  assign pg[0] = g0_r;
  assign pprev[0] = g0_r;
  assign ps[0] = '0;
  assign pc[0] = '0;
  for (genvar c = 0; c < com_pkg::CELL_N; c++) begin : g_u0
    assign pu_r[0][c] = u_r[c];
  end
  assign pm_r[0] = m_r;

  for (genvar p = 0; p < PASSES; p++) begin : g_pass
    logic [com_pkg::CELL_N-1:0] prev_r;
    com_elim u_elim (
      .clk(clk), .en(adv), .mass(pm_r[p]), .gone_i(pg[p]),
      .u0(pu_r[p][0]), .u1(pu_r[p][1]), .u2(pu_r[p][2]),
      .u3(pu_r[p][3]), .u4(pu_r[p][4]),
      .gone_r(pg[p+1]), .sum_r(ps[p+1]), .cnt_r(pc[p+1])
    );
    always_ff @(posedge clk) begin
      if (adv) begin
        for (int c = 0; c < com_pkg::CELL_N; c++) pu_r[p+1][c] <= pu_r[p][c];
        pm_r[p+1] <= pm_r[p];
        prev_r    <= pg[p];
      end
    end
    assign pprev[p+1] = prev_r;
  end

  // after the final pass the set is stable; sum/cnt of last pass are final.
  // final gone set = pg[PASSES]; sum/cnt computed over pprev[PASSES] == same set
  logic signed [SW-1:0] fs;
  com_pkg::cnt_t fc;
  logic [com_pkg::CELL_N-1:0] fg;
  assign fs = ps[PASSES];
  assign fc = pc[PASSES];
  assign fg = pg[PASSES];

  // diff stage: sum - u*cnt for each neighbour (nonnegative when kept)
  logic [SW+2:0] d_r [com_pkg::NBR_N];
  logic [com_pkg::NBR_N-1:0] k_r;
  com_pkg::cnt_t dc_r;
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int n = 0; n < com_pkg::NBR_N; n++) begin
        d_r[n] <= (SW+3)'(fs) - (SW+3)'(pu_r[PASSES][n+1] * $signed({1'b0, fc}));
        k_r[n] <= !fg[n+1] && (fc != 3'd0) && (pprev[PASSES][n+1] == 1'b0);
      end
      dc_r <= fc;
    end
  end

  // rate multiply: diff*r (diff < 2^38, r < 2^17)
  logic [56:0] q_r [com_pkg::NBR_N];
  logic [com_pkg::NBR_N-1:0] k2_r;
  com_pkg::cnt_t qc_r;
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int n = 0; n < com_pkg::NBR_N; n++)
        q_r[n] <= 57'(d_r[n][37:0]) * 57'(rate_r);
      k2_r <= k_r;
      qc_r <= dc_r;
    end
  end

  // divide by cnt*65536: drop 16 bits, flag quotients past the flow range,
  // then multiply by the reciprocal in two 17-bit halves
  logic [40:0] t [com_pkg::NBR_N];
  logic [33:0] x [com_pkg::NBR_N];
  logic [com_pkg::NBR_N-1:0] sat;
  logic [36:0] rc;
  always_comb begin
    rc = com_pkg::recip(qc_r);
    for (int n = 0; n < com_pkg::NBR_N; n++) begin
      t[n]   = q_r[n][56:16];
      sat[n] = (t[n] >= 41'({qc_r, 31'd0}));
      x[n]   = t[n][33:0];
    end
  end

  logic [53:0] ph_r [com_pkg::NBR_N];
  logic [53:0] pl_r [com_pkg::NBR_N];
  logic [com_pkg::NBR_N-1:0] sat_r;
  logic [com_pkg::NBR_N-1:0] k3_r;
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int n = 0; n < com_pkg::NBR_N; n++) begin
        ph_r[n] <= 54'(x[n][33:17]) * 54'(rc);
        pl_r[n] <= 54'(x[n][16:0]) * 54'(rc);
      end
      sat_r <= sat;
      k3_r  <= k2_r;
    end
  end

  // output stage: join the halves, quotient sits above bit 36
  logic [71:0] qs [com_pkg::NBR_N];
  com_pkg::out_beat_t o_r;
  logic [com_pkg::FLOW_W-1:0] f [com_pkg::NBR_N];
  always_comb begin
    for (int n = 0; n < com_pkg::NBR_N; n++) begin
      qs[n] = 72'({ph_r[n], 17'd0}) + 72'(pl_r[n]);
      f[n]  = !k3_r[n] ? '0 : sat_r[n] ? '1 : qs[n][66:36];
    end
  end
  always_ff @(posedge clk) begin
    if (adv) o_r <= {f[0], f[1], f[2], f[3]};
  end

  assign out_.valid = vld_r[NS-1];
  assign out_.data  = o_r;
endmodule
`default_nettype wire

// ===== rtl/core/com_checker.sv =====
// com_checker: port-level checks of the cell outflow minimization unit
// depends on com_pkg; bound to the top level
`default_nettype none
module com_checker (
  input wire logic clk,
  input wire logic rst_n,
  input wire logic in_valid,
  input wire logic in_ready,
  input wire logic out_valid,
  input wire logic out_ready,
  input wire com_pkg::out_beat_t out_data
);
  // stalled result beat holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data)) else $error("out beat dropped");
  // input blocked exactly when output is stuck
  a_rdy: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready == !(out_valid && !out_ready)) else $error("ready mismatch");
  // no result right after reset
  a_rst: assert property (@(posedge clk) !rst_n |=> !out_valid) else $error("valid after reset");
  // handshake valids are always driven
  a_known: assert property (@(posedge clk) disable iff (!rst_n)
    !$isunknown({in_valid, out_valid})) else $error("unknown valid");
endmodule
bind cell_outflow_minimization_unit com_checker u_chk (
  .clk(clk), .rst_n(rst_n), .in_valid(in_.valid), .in_ready(in_.ready),
  .out_valid(out_.valid), .out_ready(out_.ready), .out_data(out_.data)
);
`default_nettype wire

// ===== bench/com_outflow_checker.sv =====
// com_outflow_checker: watches the stencil and outflow channels and the cfg port,
// predicts every outflow beat and compares it field by field
// depends on com_pkg and com_stream_if
`default_nettype none
module com_outflow_checker (
  input  wire logic        clk,
  input  wire logic        rst_n,
  com_stream_if            in_mon,
  com_stream_if            out_mon,
  input  wire logic        cfg_psel,
  input  wire logic        cfg_penable,
  input  wire logic        cfg_pwrite,
  input  wire logic [2:2]  cfg_paddr,
  input  wire logic [31:0] cfg_pwdata,
  input  wire logic        cfg_pready,
  output int               fail_count,
  output int               pending
);
  localparam longint unsigned FLOW_SAT = 64'h7FFF_FFFF;

  logic [com_pkg::FLOW_W-1:0] eps_q;
  logic [com_pkg::RATE_W-1:0] rate_q;
  com_pkg::out_beat_t         flows_due[$];

  // minimization of differences on one cell, exact integer form
  function automatic com_pkg::out_beat_t outflows(input com_pkg::in_beat_t b,
                                                  input logic [com_pkg::FLOW_W-1:0] eps,
                                                  input logic [com_pkg::RATE_W-1:0] rate);
    longint            lvl[5];
    bit                dropped[5];
    longint            sum;
    longint            cnt;
    bit                again;
    longint unsigned   diff;
    longint unsigned   fl;
    logic [com_pkg::FLOW_W-1:0] f[4];
    begin
      for (int k = 0; k < 4; k++) f[k] = '0;
      if (b.center_debris > eps) begin
        lvl[0] = longint'($signed(b.center_altitude)) + longint'(eps);
        lvl[1] = longint'($signed(b.north_level));
        lvl[2] = longint'($signed(b.west_level));
        lvl[3] = longint'($signed(b.east_level));
        lvl[4] = longint'($signed(b.south_level));
        dropped[0] = 1'b0;
        for (int k = 1; k < 5; k++) dropped[k] = !b.neighbour_present[k-1];
        // drop every cell at or above the running average until stable
        do begin
          again = 1'b0;
          sum = longint'(b.center_debris) - longint'(eps);
          cnt = 0;
          for (int k = 0; k < 5; k++) begin
            if (!dropped[k]) begin
              sum += lvl[k];
              cnt++;
            end
          end
          if (cnt == 0) break;
          for (int k = 0; k < 5; k++) begin
            if (!dropped[k] && lvl[k] * cnt >= sum) begin
              dropped[k] = 1'b1;
              again = 1'b1;
            end
          end
        end while (again);
        if (cnt != 0) begin
          for (int k = 1; k < 5; k++) begin
            if (!dropped[k]) begin
              diff = longint'(sum - lvl[k] * cnt);
              fl = diff * longint'(rate) / (longint'(cnt) * 65536);
              if (fl > FLOW_SAT) fl = FLOW_SAT;
              f[k-1] = fl[com_pkg::FLOW_W-1:0];
            end
          end
        end
      end
      return '{flow_north: f[0], flow_west: f[1], flow_east: f[2], flow_south: f[3]};
    end
  endfunction

  initial begin
    fail_count = 0;
    pending = 0;
  end

  always @(posedge clk) begin
    com_pkg::out_beat_t want;
    com_pkg::out_beat_t got;
    if (!rst_n) begin
      eps_q = com_pkg::EPS_RESET;
      rate_q = com_pkg::RATE_RESET;
      flows_due.delete();
    end else begin
      // register write on the access phase
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready) begin
        if (cfg_paddr[2] == com_pkg::REG_EPSILON) eps_q = cfg_pwdata[com_pkg::FLOW_W-1:0];
        else rate_q = cfg_pwdata[com_pkg::RATE_W-1:0];
      end
      // stencil beat in
      if (in_mon.valid && in_mon.ready) flows_due.push_back(outflows(in_mon.data, eps_q, rate_q));
      // outflow beat out
      if (out_mon.valid && out_mon.ready) begin
        got = out_mon.data;
        if (flows_due.size() == 0) begin
          $error("outflow beat with nothing expected");
          fail_count++;
        end else begin
          want = flows_due.pop_front();
          if (got.flow_north !== want.flow_north) begin
            $error("flow_north expected %0d got %0d", want.flow_north, got.flow_north);
            fail_count++;
          end
          if (got.flow_west !== want.flow_west) begin
            $error("flow_west expected %0d got %0d", want.flow_west, got.flow_west);
            fail_count++;
          end
          if (got.flow_east !== want.flow_east) begin
            $error("flow_east expected %0d got %0d", want.flow_east, got.flow_east);
            fail_count++;
          end
          if (got.flow_south !== want.flow_south) begin
            $error("flow_south expected %0d got %0d", want.flow_south, got.flow_south);
            fail_count++;
          end
        end
      end
    end
    pending = flows_due.size();
  end
endmodule
`default_nettype wire

// ===== bench/cell_outflow_minimization_unit_tb.sv =====
// cell_outflow_minimization_unit_tb: stimulus, cfg phases and verdict
// depends on com_pkg, com_stream_if, com_outflow_checker and the unit itself
`default_nettype none
module cell_outflow_minimization_unit_tb;
  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_psel = 1'b0;
  logic        cfg_penable = 1'b0;
  logic        cfg_pwrite = 1'b0;
  logic [2:2]  cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;
  int          fail_count;
  int          pending;
  bit          no_idle = 1'b0;
  bit          hold_req = 1'b0;
  int          hold_left = 0;
  int          beats_sent = 0;
  logic [com_pkg::FLOW_W-1:0] eps_now = com_pkg::EPS_RESET;

  com_stream_if #(.T(com_pkg::in_beat_t))  in_ch (clk);
  com_stream_if #(.T(com_pkg::out_beat_t)) out_ch (clk);

  // clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  cell_outflow_minimization_unit dut (
    .clk(clk), .rst_n(rst_n), .in_(in_ch), .out_(out_ch),
    .cfg_psel(cfg_psel), .cfg_penable(cfg_penable), .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr), .cfg_pwdata(cfg_pwdata), .cfg_prdata(cfg_prdata),
    .cfg_pready(cfg_pready)
  );

  com_outflow_checker chk (
    .clk(clk), .rst_n(rst_n), .in_mon(in_ch), .out_mon(out_ch),
    .cfg_psel(cfg_psel), .cfg_penable(cfg_penable), .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr), .cfg_pwdata(cfg_pwdata), .cfg_pready(cfg_pready),
    .fail_count(fail_count), .pending(pending)
  );

  initial begin
    in_ch.valid = 1'b0;
    in_ch.data = '0;
    out_ch.ready = 1'b0;
  end

  // receiver: random stalls, plus a long hold-off on request
  initial begin
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_left = 300;
        hold_req = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= no_idle ? 1'b1 : ($urandom_range(99) >= 22);
      end
    end
  end

  // one stencil beat, with random gaps ahead of it
  task automatic send_cell(input com_pkg::in_beat_t b);
    begin
      @(negedge clk);
      while (!no_idle && $urandom_range(99) < 22) begin
        in_ch.valid <= 1'b0;
        @(negedge clk);
      end
      in_ch.data <= b;
      in_ch.valid <= 1'b1;
      @(posedge clk);
      while (!in_ch.ready) @(posedge clk);
      beats_sent++;
    end
  endtask

  task automatic drain;
    begin
      @(negedge clk);
      in_ch.valid <= 1'b0;
      while (pending != 0) @(negedge clk);
      repeat (12) @(negedge clk);
    end
  endtask

  // apb write: setup then access
  task automatic cfg_write(input logic idx, input logic [31:0] val);
    begin
      drain();
      cfg_psel <= 1'b1;
      cfg_pwrite <= 1'b1;
      cfg_penable <= 1'b0;
      cfg_paddr[2] <= idx;
      cfg_pwdata <= val;
      @(negedge clk);
      cfg_penable <= 1'b1;
      @(negedge clk);
      cfg_psel <= 1'b0;
      cfg_penable <= 1'b0;
      cfg_pwrite <= 1'b0;
      if (idx == com_pkg::REG_EPSILON) eps_now = val[com_pkg::FLOW_W-1:0];
    end
  endtask

  function automatic com_pkg::in_beat_t mk(input longint deb, input int alt, input int n,
                                           input int w, input int e, input int s,
                                           input logic [3:0] pres);
    com_pkg::in_beat_t b;
    begin
      if (deb < 0) deb = 0;
      if (deb > 64'h7FFF_FFFF) deb = 64'h7FFF_FFFF;
      b.center_debris = deb[com_pkg::FLOW_W-1:0];
      b.center_altitude = alt;
      b.north_level = n;
      b.west_level = w;
      b.east_level = e;
      b.south_level = s;
      b.neighbour_present = pres;
      return b;
    end
  endfunction

  // terrain-like cell: neighbours near the centre, debris above threshold unless clipped to the field maximum
  function automatic com_pkg::in_beat_t terrain_cell;
    int alt;
    int spread;
    begin
      alt = int'($urandom) >>> 4;
      spread = 1 << $urandom_range(4, 22);
      return mk(longint'(eps_now) + $urandom_range(1, spread),
                alt, alt + $urandom_range(0, 2 * spread) - spread,
                alt + $urandom_range(0, 2 * spread) - spread,
                alt + $urandom_range(0, 2 * spread) - spread,
                alt + $urandom_range(0, 2 * spread) - spread,
                ($urandom_range(99) < 70) ? 4'hF : 4'($urandom));
    end
  endfunction

  function automatic com_pkg::in_beat_t noise_cell;
    begin
      return mk(longint'($urandom) & 64'h7FFF_FFFF, $urandom, $urandom, $urandom, $urandom,
                $urandom, 4'($urandom));
    end
  endfunction

  task automatic random_run(input int count, input bit mid_pause);
    begin
      for (int k = 0; k < count; k++) begin
        if (mid_pause && k == count / 2) drain();
        send_cell(($urandom_range(99) < 75) ? terrain_cell() : noise_cell());
      end
    end
  endtask

  localparam int MAXI = 32'h7FFF_FFFF;
  localparam int MINI = 32'h8000_0000;

  initial begin
    repeat (10) @(negedge clk);
    rst_n = 1'b1;

    // directed: reset settings, field extremes and the special cases
    send_cell(mk(0, 0, 0, 0, 0, 0, 4'hF));                          // no debris
    send_cell(mk(66, 0, -100, -100, -100, -100, 4'hF));             // debris at epsilon
    send_cell(mk(67, 0, -100, -100, -100, -100, 4'hF));
    send_cell(mk(MAXI, 0, 0, 0, 0, 0, 4'h0));                       // no neighbours
    send_cell(mk(MAXI, MINI, MAXI, MAXI, MAXI, MAXI, 4'hF));        // all neighbours higher
    send_cell(mk(MAXI, MAXI, MINI, MINI, MINI, MINI, 4'hF));
    send_cell(mk(MAXI, MAXI, MINI, MAXI, MINI, MAXI, 4'h5));
    send_cell(mk(65536, 1000, 0, 500, 2000, -3000, 4'hF));
    send_cell(mk(1 << 20, 0, 0, 0, 0, 0, 4'hF));                    // flat ground
    for (int k = 0; k < 16; k += 3) send_cell(mk(1 << 18, 0, -10, -20, -30, -40, 4'(k)));

    // rate one, no threshold
    cfg_write(com_pkg::REG_EPSILON, 32'd0);
    cfg_write(com_pkg::REG_RATE, 32'd65536);
    send_cell(mk(1, 0, 0, 0, 0, 0, 4'hF));
    send_cell(mk(0, MINI, MINI, MINI, MINI, MINI, 4'hF));
    random_run(200, 1'b1);

    // rate above one, saturation, sender and receiver never idle
    cfg_write(com_pkg::REG_RATE, 32'd131071);
    send_cell(mk(MAXI, MAXI, MINI, MINI, MINI, MINI, 4'hF));
    send_cell(mk(MAXI, MAXI, MINI, MAXI, MAXI, MAXI, 4'h1));
    no_idle = 1'b1;
    random_run(200, 1'b0);
    no_idle = 1'b0;

    // zero rate, long receiver hold-off fills the pipe
    cfg_write(com_pkg::REG_RATE, 32'd0);
    cfg_write(com_pkg::REG_EPSILON, 32'd1000);
    hold_req = 1'b1;
    random_run(200, 1'b0);

    // largest threshold
    cfg_write(com_pkg::REG_EPSILON, 32'h7FFF_FFFF);
    cfg_write(com_pkg::REG_RATE, 32'd65535);
    send_cell(mk(MAXI, 0, MINI, MINI, MINI, MINI, 4'hF));
    random_run(100, 1'b0);

    // mid settings
    cfg_write(com_pkg::REG_EPSILON, $urandom_range(0, 1 << 16));
    cfg_write(com_pkg::REG_RATE, $urandom_range(1, 65536));
    hold_req = 1'b1;
    random_run(300, 1'b0);

    drain();
    $display("covered %0d stencil beats over six register settings", beats_sent);
    $display("incl. threshold and rate extremes, saturation, pipe fill and drain");
    if (fail_count == 0) begin
      $display("cell_outflow_minimization_unit regression: pass");
    end else begin
      $display("cell_outflow_minimization_unit regression: fail");
    end
    $finish;
  end

  // run limit
  initial begin
    #8000000;
    $display("cell_outflow_minimization_unit regression: fail");
    $finish;
  end
endmodule
`default_nettype wire
